@@ sv/tps_pkg.sv @@
`default_nettype none

package tps_pkg;

   // Widths of timers and configuration fields
   localparam int TIME_WIDTH  = 24;
   localparam int WAIT_WIDTH  = 24;
   localparam int TICK_WIDTH  = 8;
   localparam int COUNT_WIDTH = 8;
   localparam int TALLY_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 24;
   localparam int CMP_WIDTH = (TIME_WIDTH > WAIT_WIDTH) ? TIME_WIDTH : WAIT_WIDTH;

   // Reset values of the configuration registers
   localparam logic [TICK_WIDTH-1:0] PULSE_TICKS_RESET  = TICK_WIDTH'(10);
   localparam logic [TICK_WIDTH-1:0] SETTLE_TICKS_RESET = TICK_WIDTH'(10);
   localparam logic [WAIT_WIDTH-1:0] INITIAL_WAIT_RESET = WAIT_WIDTH'(1000);
   localparam logic [WAIT_WIDTH-1:0] MAX_WAIT_RESET     = WAIT_WIDTH'(16000);

   // Event kinds
   typedef enum logic [2:0] {
      MODE_TICK    = 3'd0,
      MODE_POWER   = 3'd1,
      MODE_RADIO   = 3'd2,
      MODE_BYTES   = 3'd3,
      MODE_SUSPEND = 3'd4,
      MODE_RESUME  = 3'd5
   } mode_type;

   // Sequencer phase
   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_PULSE  = 2'd1,
      PHASE_SETTLE = 2'd2
   } phase_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PULSE_TICKS  = 2'd0,
      CSR_SETTLE_TICKS = 2'd1,
      CSR_INITIAL_WAIT = 2'd2,
      CSR_MAX_WAIT     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [TICK_WIDTH-1:0] pulse_ticks;
      logic [TICK_WIDTH-1:0] settle_ticks;
      logic [WAIT_WIDTH-1:0] initial_wait;
      logic [WAIT_WIDTH-1:0] max_wait;
   } cfg_type;

   typedef struct packed {
      phase_type              phase;
      logic                   believed_on;
      logic                   want_on;
      logic                   radio_blocked;
      logic                   amp_off;
      logic                   suspended;
      logic                   pin;
      logic                   pending;
      logic [TICK_WIDTH-1:0]  delay;
      logic [TIME_WIDTH-1:0]  since_toggle;
      logic [WAIT_WIDTH-1:0]  retry_wait;
      logic [TALLY_WIDTH-1:0] tally;
   } state_type;

endpackage

`default_nettype wire

@@ sv/tps_step.sv @@
`default_nettype none

// Next-state logic for one event
module tps_step (
   input  var tps_pkg::state_type                   cur,
   input  var tps_pkg::cfg_type                     cfg,
   input  var logic [2:0]                           mode,
   input  var logic                                 flag_value,
   input  var logic [tps_pkg::COUNT_WIDTH-1:0]      byte_count,
   output tps_pkg::state_type                       nxt,
   output logic [tps_pkg::COUNT_WIDTH-1:0]          forwarded
);

   logic                                target;
   logic                                changed;
   logic [tps_pkg::TALLY_WIDTH:0]       tally_sum;
   logic [tps_pkg::WAIT_WIDTH:0]        doubled;
   logic [tps_pkg::CMP_WIDTH-1:0]       since_ext;
   logic [tps_pkg::CMP_WIDTH-1:0]       retry_ext;
   logic                                retry_due;

   // Shared terms
   always_comb begin
      target    = cur.want_on & ~cur.suspended;
      tally_sum = {1'b0, cur.tally} + (tps_pkg::TALLY_WIDTH + 1)'(byte_count);
      doubled   = {cur.retry_wait, 1'b0};
      since_ext = tps_pkg::CMP_WIDTH'(cur.since_toggle);
      retry_ext = tps_pkg::CMP_WIDTH'(cur.retry_wait);
      retry_due = (cur.phase == tps_pkg::PHASE_IDLE) && (since_ext > retry_ext);
      changed   = (flag_value != cur.want_on);
   end

   // Event decode and state update
   always_comb begin
      nxt       = cur;
      forwarded = '0;
      unique case (mode)
         tps_pkg::MODE_TICK: begin
            if (cur.since_toggle != '1) begin
               nxt.since_toggle = cur.since_toggle + 1'b1;
            end
            if (cur.pending) begin
               if (cur.delay <= tps_pkg::TICK_WIDTH'(1)) begin
                  // deferred work step
                  nxt.pending = 1'b0;
                  nxt.amp_off = cur.suspended | ~cur.want_on | cur.radio_blocked;
                  unique case (cur.phase)
                     tps_pkg::PHASE_IDLE: begin
                        if (target != cur.believed_on) begin
                           nxt.pin     = 1'b1;
                           nxt.phase   = tps_pkg::PHASE_PULSE;
                           nxt.pending = 1'b1;
                           nxt.delay   = cfg.pulse_ticks;
                        end
                     end
                     tps_pkg::PHASE_PULSE: begin
                        nxt.pin          = 1'b0;
                        nxt.since_toggle = '0;
                        nxt.believed_on  = ~cur.believed_on;
                        nxt.phase        = tps_pkg::PHASE_SETTLE;
                        nxt.pending      = 1'b1;
                        nxt.delay        = cfg.settle_ticks;
                     end
                     default: begin
                        nxt.phase = tps_pkg::PHASE_IDLE;
                        if (cur.suspended) begin
                           nxt.pending = 1'b1;
                           nxt.delay   = '0;
                        end
                     end
                  endcase
               end else begin
                  nxt.delay = cur.delay - 1'b1;
               end
            end
         end
         tps_pkg::MODE_POWER: begin
            if (changed) begin
               nxt.want_on = flag_value;
               if (!flag_value) begin
                  nxt.retry_wait = cfg.initial_wait;
               end
               if (!cur.suspended && !cur.pending) begin
                  nxt.pending = 1'b1;
                  nxt.delay   = '0;
               end
            end
         end
         tps_pkg::MODE_RADIO: begin
            nxt.radio_blocked = flag_value;
            if (!cur.suspended && !cur.pending) begin
               nxt.pending = 1'b1;
               nxt.delay   = '0;
            end
         end
         tps_pkg::MODE_BYTES: begin
            if (cur.want_on) begin
               forwarded = byte_count;
            end else begin
               nxt.tally = tally_sum[tps_pkg::TALLY_WIDTH] ? '1
                                                           : tally_sum[tps_pkg::TALLY_WIDTH-1:0];
               // retry: assume the module came up on its own
               if (!cur.believed_on && retry_due) begin
                  nxt.tally       = '0;
                  nxt.believed_on = 1'b1;
                  nxt.retry_wait  = (doubled > {1'b0, cfg.max_wait}) ? cfg.max_wait
                                    : doubled[tps_pkg::WAIT_WIDTH-1:0];
                  if (!cur.suspended && !cur.pending) begin
                     nxt.pending = 1'b1;
                     nxt.delay   = '0;
                  end
               end
            end
         end
         tps_pkg::MODE_SUSPEND: begin
            nxt.suspended = 1'b1;
            nxt.amp_off   = 1'b1;
            nxt.pending   = 1'b1;
            unique case (cur.phase)
               tps_pkg::PHASE_PULSE:  nxt.delay = cfg.pulse_ticks;
               tps_pkg::PHASE_SETTLE: nxt.delay = cfg.settle_ticks;
               default:               nxt.delay = '0;
            endcase
         end
         tps_pkg::MODE_RESUME: begin
            nxt.suspended = 1'b0;
            if (!cur.pending) begin
               nxt.pending = 1'b1;
               nxt.delay   = '0;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/toggle_pin_power_sequencer.sv @@
// Toggle-pin power sequencer.
// The result of an event is registered at its accepting edge; the state update
// is a single pass of logic. One event per cycle while no result is held back.
// Synchronous active-high reset restores all state and configuration defaults
// and empties the result register; no clearing sweep is needed.
`default_nettype none

module toggle_pin_power_sequencer (
   input  var logic                                  clock,
   input  var logic                                  reset,
   // event channel
   input  var logic                                  req_valid,
   output logic                                      req_ready,
   input  var logic [2:0]                            req_mode,
   input  var logic                                  req_flag_value,
   input  var logic [tps_pkg::COUNT_WIDTH-1:0]       req_byte_count,
   // result channel
   output logic                                      rsp_valid,
   input  var logic                                  rsp_ready,
   output logic                                      rsp_pin_level,
   output logic                                      rsp_amp_enable,
   output logic                                      rsp_believed_on,
   output logic [1:0]                                rsp_seq_phase,
   output logic [tps_pkg::COUNT_WIDTH-1:0]           rsp_bytes_forwarded,
   output logic [tps_pkg::TALLY_WIDTH-1:0]           rsp_discarded_total,
   // configuration write channel
   input  var logic                                  csr_valid,
   output logic                                      csr_ready,
   input  var logic [tps_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  var logic [tps_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   tps_pkg::state_type                   state_ff;
   tps_pkg::state_type                   state_in;
   tps_pkg::cfg_type                     cfg_ff;
   logic [tps_pkg::COUNT_WIDTH-1:0]      fwd_in;
   logic                                 req_xfer;
   logic                                 rsp_valid_ff;
   logic                                 pin_ff;
   logic                                 amp_ff;
   logic                                 believed_ff;
   logic [1:0]                           phase_ff;
   logic [tps_pkg::COUNT_WIDTH-1:0]      fwd_ff;
   logic [tps_pkg::TALLY_WIDTH-1:0]      tally_ff;

   // Handshake: a new event enters whenever the result slot frees up
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_xfer  = req_valid & req_ready;
   assign csr_ready = 1'b1;

   tps_step u_step (
      .cur        (state_ff),
      .cfg        (cfg_ff),
      .mode       (req_mode),
      .flag_value (req_flag_value),
      .byte_count (req_byte_count),
      .nxt        (state_in),
      .forwarded  (fwd_in)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks  <= tps_pkg::PULSE_TICKS_RESET;
         cfg_ff.settle_ticks <= tps_pkg::SETTLE_TICKS_RESET;
         cfg_ff.initial_wait <= tps_pkg::INITIAL_WAIT_RESET;
         cfg_ff.max_wait     <= tps_pkg::MAX_WAIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tps_pkg::CSR_PULSE_TICKS:
               cfg_ff.pulse_ticks <= csr_data[tps_pkg::TICK_WIDTH-1:0];
            tps_pkg::CSR_SETTLE_TICKS:
               cfg_ff.settle_ticks <= csr_data[tps_pkg::TICK_WIDTH-1:0];
            tps_pkg::CSR_INITIAL_WAIT:
               cfg_ff.initial_wait <= csr_data[tps_pkg::WAIT_WIDTH-1:0];
            tps_pkg::CSR_MAX_WAIT:
               cfg_ff.max_wait <= csr_data[tps_pkg::WAIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= tps_pkg::PHASE_IDLE;
         state_ff.believed_on   <= 1'b0;
         state_ff.want_on       <= 1'b0;
         state_ff.radio_blocked <= 1'b1;
         state_ff.amp_off       <= 1'b1;
         state_ff.suspended     <= 1'b0;
         state_ff.pin           <= 1'b0;
         state_ff.pending       <= 1'b0;
         state_ff.delay         <= '0;
         state_ff.since_toggle  <= '0;
         state_ff.retry_wait    <= tps_pkg::INITIAL_WAIT_RESET;
         state_ff.tally         <= '0;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pin_ff      <= state_in.pin;
         amp_ff      <= ~state_in.amp_off;
         believed_ff <= state_in.believed_on;
         phase_ff    <= state_in.phase;
         fwd_ff      <= fwd_in;
         tally_ff    <= state_in.tally;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pin_level       = pin_ff;
   assign rsp_amp_enable      = amp_ff;
   assign rsp_believed_on     = believed_ff;
   assign rsp_seq_phase       = phase_ff;
   assign rsp_bytes_forwarded = fwd_ff;
   assign rsp_discarded_total = tally_ff;

endmodule

`default_nettype wire
